### hdl/mbss_pkg.sv
`timescale 1ns / 1ps

package mbss_pkg;

	localparam int MAX_DIM = 64;
	localparam int IDX_W = $clog2(MAX_DIM);
	localparam int N_W = $clog2(MAX_DIM + 1);
	localparam int ADDR_W = 2 * IDX_W;
	localparam int STORE_DEPTH = 1 << ADDR_W;

	localparam int SIZE_W = 7;
	localparam int ELEM_W = 32;
	localparam int SUM_W = 40;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(2);
	localparam logic [0:0] REG_MATRIX_SIZE = 1'b0;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// One classified element on its way from the front to the back.
	typedef struct packed {
		logic signed [ELEM_W-1:0] value;
		logic [ADDR_W-1:0]        wr_addr;
		logic [ADDR_W-1:0]        rd_addr;
		logic                     border;
		logic                     compare;
		logic                     last;
	} elem_entry_t;

endpackage

### hdl/mbss_if.sv
`timescale 1ns / 1ps

interface mbss_elem_if
	import mbss_pkg::*;
	();
	logic                     valid;
	logic                     ready;
	logic signed [ELEM_W-1:0] element_value;

	modport source(output valid, output element_value, input ready);
	modport sink(input valid, input element_value, output ready);
endinterface

interface mbss_result_if
	import mbss_pkg::*;
	();
	logic                    valid;
	logic                    ready;
	logic signed [SUM_W-1:0] border_sum;
	logic                    is_symmetric;

	modport source(output valid, output border_sum, output is_symmetric, input ready);
	modport sink(input valid, input border_sum, input is_symmetric, output ready);
endinterface

### hdl/mbss_front.sv
`timescale 1ns / 1ps

module mbss_front
	import mbss_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr,
	input  logic [SIZE_W-1:0]        cfg_size,
	output logic [SIZE_W-1:0]        size,
	input  logic                     elem_valid,
	input  logic signed [ELEM_W-1:0] elem_value,
	output logic                     elem_ready,
	input  logic                     q_full,
	output logic                     push,
	output elem_entry_t              push_entry
);

	logic [SIZE_W-1:0] size_q;
	logic [IDX_W-1:0]  row_q;
	logic [IDX_W-1:0]  col_q;
	logic [N_W-1:0]    n_eff;
	logic [IDX_W-1:0]  n_last;
	logic              row_end;
	logic              col_end;

	// clamp the programmed size into 2..MAX_DIM
	always_comb begin
		if (size_q < SIZE_W'(2)) begin
			n_eff = N_W'(2);
		end else if (32'(size_q) > MAX_DIM) begin
			n_eff = N_W'(MAX_DIM);
		end else begin
			n_eff = N_W'(size_q);
		end
	end

	assign n_last  = IDX_W'(n_eff - N_W'(1));
	assign row_end = (row_q == n_last);
	assign col_end = (col_q == n_last);

	assign size       = size_q;
	assign elem_ready = !q_full;
	assign push       = elem_valid && elem_ready;

	always_comb begin
		push_entry.value   = elem_value;
		push_entry.wr_addr = {row_q, col_q};
		push_entry.rd_addr = {col_q, row_q};
		push_entry.border  = (row_q == '0) || row_end || (col_q == '0) || col_end;
		push_entry.compare = (row_q > col_q);
		push_entry.last    = row_end && col_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
			row_q  <= '0;
			col_q  <= '0;
		end else if (cfg_wr) begin
			size_q <= cfg_size;
			row_q  <= '0;
			col_q  <= '0;
		end else if (push) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + IDX_W'(1);
			end else begin
				col_q <= col_q + IDX_W'(1);
			end
		end
	end

endmodule

### hdl/mbss_queue.sv
`timescale 1ns / 1ps

module mbss_queue
	import mbss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  elem_entry_t push_entry,
	output logic        full,
	input  logic        pop,
	output logic        head_valid,
	output elem_entry_t head_entry
);

	elem_entry_t          slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;

	assign full       = (count_q == Q_CNT_W'(Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + Q_CNT_W'(1);
				2'b01:   count_q <= count_q - Q_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hdl/mbss_back.sv
`timescale 1ns / 1ps

module mbss_back
	import mbss_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    clear,
	input  logic                    head_valid,
	input  elem_entry_t             head_entry,
	output logic                    pop,
	output logic                    res_valid,
	input  logic                    res_ready,
	output logic signed [SUM_W-1:0] res_sum,
	output logic                    res_sym
);

	logic [ELEM_W-1:0]       store_mem [STORE_DEPTH];
	logic [ELEM_W-1:0]       mirror_s1;
	elem_entry_t             entry_s1;
	logic                    valid_s1;
	logic                    adv_s1;

	logic signed [SUM_W-1:0] acc_q;
	logic                    mismatch_q;
	logic                    out_valid_q;
	logic signed [SUM_W-1:0] out_sum_q;
	logic                    out_sym_q;

	logic signed [SUM_W:0]   sum_wide;
	logic signed [SUM_W-1:0] sum_sat;
	logic signed [SUM_W-1:0] acc_nxt;
	logic                    mismatch_nxt;

	// hold the last element while an earlier result is still waiting
	assign adv_s1 = valid_s1 && !(entry_s1.last && out_valid_q && !res_ready);
	assign pop    = head_valid && (!valid_s1 || adv_s1);

	// the mirror was written by an earlier pop, so the registered read sees it
	always_ff @(posedge clk) begin
		if (pop) begin
			store_mem[head_entry.wr_addr] <= head_entry.value;
			mirror_s1                     <= store_mem[head_entry.rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			entry_s1 <= head_entry;
		end
	end

	always_comb begin
		sum_wide = (SUM_W+1)'(acc_q) + (SUM_W+1)'(entry_s1.value);
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_sat = sum_wide[SUM_W-1:0];
		end
		acc_nxt      = entry_s1.border ? sum_sat : acc_q;
		mismatch_nxt = mismatch_q ||
			(entry_s1.compare && (mirror_s1 != ELEM_W'(entry_s1.value)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			acc_q       <= '0;
			mismatch_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (clear) begin
			valid_s1    <= 1'b0;
			acc_q       <= '0;
			mismatch_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end

			if (adv_s1 && entry_s1.last) begin
				acc_q      <= '0;
				mismatch_q <= 1'b0;
			end else if (adv_s1) begin
				acc_q      <= acc_nxt;
				mismatch_q <= mismatch_nxt;
			end

			if (adv_s1 && entry_s1.last) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && entry_s1.last) begin
			out_sum_q <= acc_nxt;
			out_sym_q <= !mismatch_nxt;
		end
	end

	assign res_valid = out_valid_q;
	assign res_sum   = out_sum_q;
	assign res_sym   = out_sym_q;

endmodule

### hdl/matrix_border_sum_symmetry_unit.sv
`timescale 1ns / 1ps

// channel   dir  handshake            payload
// elem      in   valid / ready        element_value[31:0] signed
// result    out  valid / ready        border_sum[39:0] signed, is_symmetric
// apb       in   psel/penable, pready matrix_size at byte address 0
//
// One element per cycle while the queue has room; the element store has one
// write and one read port, both used by the single back-end pop each cycle.
// The result is registered after the queue and the stage-one register.
// A four-entry queue separates element intake from store access, so intake
// continues while a finished result waits on result.ready, until the next
// matrix's last element reaches the back end and the queue fills.
// Reset clears position, sum and flags; store contents are left undefined.

module matrix_border_sum_symmetry_unit
	import mbss_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	mbss_elem_if.sink         elem,
	mbss_result_if.source     result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	logic              cfg_wr;
	logic [SIZE_W-1:0] size;
	logic              q_full;
	logic              push;
	elem_entry_t       push_entry;
	logic              pop;
	logic              head_valid;
	elem_entry_t       head_entry;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1] == REG_MATRIX_SIZE);
	assign prdata = (paddr[APB_AW-1] == REG_MATRIX_SIZE) ? APB_DW'(size) : '0;

	mbss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_wr),
		.cfg_size   (pwdata[SIZE_W-1:0]),
		.size       (size),
		.elem_valid (elem.valid),
		.elem_value (elem.element_value),
		.elem_ready (elem.ready),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	mbss_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	mbss_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (cfg_wr),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.res_sum    (result.border_sum),
		.res_sym    (result.is_symmetric)
	);

endmodule

### hdl/mbss_checker.sv
`timescale 1ns / 1ps

module mbss_checker
	import mbss_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [SUM_W-1:0] out_sum,
	input logic                    out_sym,
	input logic                    psel,
	input logic                    penable,
	input logic                    pwrite,
	input logic [APB_AW-1:0]       paddr,
	input logic [APB_DW-1:0]       pwdata,
	input logic [APB_DW-1:0]       prdata
);

	logic seen_input_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_input_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			seen_input_q <= 1'b1;
		end
	end

	// a stalled result keeps its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sum) && $stable(out_sym))
		else $error("result changed while stalled");

	// no result before any element was taken
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> seen_input_q)
		else $error("result without any accepted element");

	// the size register reads back what was written
	a_size_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && (paddr == '0)
		##1 (paddr == '0) |-> prdata == APB_DW'($past(pwdata[SIZE_W-1:0])))
		else $error("matrix_size readback mismatch");

endmodule

bind matrix_border_sum_symmetry_unit mbss_checker u_mbss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (elem.valid),
	.in_ready  (elem.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_sum   (result.border_sum),
	.out_sym   (result.is_symmetric),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata)
);
